// File: hw/rtl/pesd_pkg.sv
`default_nettype none
package pesd_pkg;

  localparam int MAX_PACKET_BYTES = 65536;
  localparam int CNT_W = $clog2(MAX_PACKET_BYTES + 1);
  // wide enough for the count and for length + 6
  localparam int CMP_W = (CNT_W > 17) ? CNT_W : 17;

  localparam int OUT_DEPTH = 3;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  localparam logic [7:0] START_CODE_LAST = 8'h01;
  localparam logic [7:0] AV_ID_LOW       = 8'hC0;
  localparam logic [7:0] AV_ID_HIGH      = 8'hEF;
  localparam logic [3:0] PREFIX_PTS_ONLY = 4'b0010;
  localparam logic [3:0] PREFIX_PTS_DTS  = 4'b0011;
  localparam logic [3:0] PREFIX_DTS      = 4'b0001;
  localparam logic [7:0] NEED_PTS_ONLY   = 8'd5;
  localparam logic [7:0] NEED_PTS_DTS    = 8'd10;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_HEAD = 3'd1,
    PH_OPT  = 3'd2,
    PH_DATA = 3'd3,
    PH_PAY  = 3'd4,
    PH_DONE = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_HEADER  = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_START    = 3'd1,
    ERR_FLAGS    = 3'd2,
    ERR_PREFIX   = 3'd3,
    ERR_MARKER   = 3'd4,
    ERR_SHORT    = 3'd5,
    ERR_OVERSIZE = 3'd6
  } err_t;

  typedef enum logic [1:0] {
    FLAGS_NONE    = 2'b00,
    FLAGS_BAD     = 2'b01,
    FLAGS_PTS     = 2'b10,
    FLAGS_PTS_DTS = 2'b11
  } flags_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       packet_start;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic        last_payload;
    logic [7:0]  stream_id;
    logic [15:0] pes_length;
    logic        has_timestamps;
    logic [32:0] pts;
    logic [32:0] dts;
    logic [2:0]  error_code;
  } out_item_t;

endpackage
`default_nettype wire

// File: hw/rtl/pesd_in_if.sv
`default_nettype none
interface pesd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       packet_start;

  modport source (output valid, output in_byte, output packet_start, input ready);
  modport sink (input valid, input in_byte, input packet_start, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/pesd_out_if.sv
`default_nettype none
interface pesd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  payload_byte;
  logic        last_payload;
  logic [7:0]  stream_id;
  logic [15:0] pes_length;
  logic        has_timestamps;
  logic [32:0] pts;
  logic [32:0] dts;
  logic [2:0]  error_code;

  modport source (
    output valid, output kind, output payload_byte, output last_payload,
    output stream_id, output pes_length, output has_timestamps, output pts,
    output dts, output error_code, input ready
  );
  modport sink (
    input valid, input kind, input payload_byte, input last_payload,
    input stream_id, input pes_length, input has_timestamps, input pts,
    input dts, input error_code, output ready
  );
endinterface
`default_nettype wire

// File: hw/rtl/pesd_parser.sv
`default_nettype none
module pesd_parser
  import pesd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      acc,
  input  wire in_item_t  item,
  output logic           res_valid,
  output out_item_t      res
);

  phase_t            phase_r, phase_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [7:0]        sc_r, sc_nxt;
  logic [15:0]       len_r, len_nxt;
  logic [1:0]        flg_r, flg_nxt;
  logic [7:0]        hdr_r, hdr_nxt;
  logic [39:0]       stamp_r, stamp_nxt;
  logic [32:0]       pts_r, pts_nxt;
  logic [32:0]       dts_r, dts_nxt;
  logic              res_valid_r, res_valid_nxt;
  out_item_t         res_r, res_nxt;

  // values after an optional packet start has cleared them
  phase_t            ph;
  logic [CNT_W-1:0]  cnt, cnt_inc;
  logic [7:0]        sc, len_hi, b;
  logic [15:0]       len;
  logic [1:0]        flg;
  logic [7:0]        hdr, need;
  logic [39:0]       stamp;
  logic [32:0]       pts_c, dts_c;

  // decoded step
  logic              active, oversize, fail, hdone, go_opt, go_data, pay, last;
  logic              hd_to_done;
  err_t              code;
  logic [7:0]        sc_n, hdr_n;
  logic [15:0]       len_n;
  logic [1:0]        flg_n;
  logic [39:0]       stamp_n;
  logic [32:0]       pts_n, dts_n, ts;
  err_t              ts_err;
  logic [CMP_W-1:0]  cnt_inc_w, idx_w, end_w;

  function automatic err_t stamp_check(input logic [39:0] v, input logic [3:0] prefix);
    err_t e;
    if (v[39:36] != prefix) begin
      e = ERR_PREFIX;
    end else if (!v[32] || !v[16] || !v[0]) begin
      e = ERR_MARKER;
    end else begin
      e = ERR_NONE;
    end
    return e;
  endfunction

  always_comb begin
    ph    = item.packet_start ? PH_HEAD : phase_r;
    cnt   = item.packet_start ? '0 : cnt_r;
    sc    = item.packet_start ? '0 : sc_r;
    len   = item.packet_start ? '0 : len_r;
    flg   = item.packet_start ? '0 : flg_r;
    hdr   = item.packet_start ? '0 : hdr_r;
    stamp = item.packet_start ? '0 : stamp_r;
    pts_c = item.packet_start ? '0 : pts_r;
    dts_c = item.packet_start ? '0 : dts_r;
    b     = item.in_byte;

    active   = (ph == PH_HEAD) || (ph == PH_OPT) || (ph == PH_DATA) || (ph == PH_PAY);
    oversize = cnt >= CNT_W'(MAX_PACKET_BYTES);
    cnt_inc  = cnt + CNT_W'(1);
    cnt_inc_w = CMP_W'(cnt_inc);
    idx_w     = CMP_W'(cnt);

    sc_n    = sc;
    len_n   = len;
    flg_n   = flg;
    hdr_n   = hdr;
    stamp_n = stamp;
    pts_n   = pts_c;
    dts_n   = dts_c;
    fail    = 1'b0;
    code    = ERR_NONE;
    hdone   = 1'b0;
    go_opt  = 1'b0;
    go_data = 1'b0;
    pay     = 1'b0;
    last    = 1'b0;
    need    = '0;
    ts_err  = ERR_NONE;
    len_hi  = '0;
    ts      = '0;

    if (active) begin
      if (oversize) begin
        fail = 1'b1;
        code = ERR_OVERSIZE;
      end else begin
        case (ph)
          PH_HEAD: begin
            if (idx_w < CMP_W'(2)) begin
              if (b != 8'h00) begin
                fail = 1'b1;
                code = ERR_START;
              end
            end else if (idx_w == CMP_W'(2)) begin
              if (b != START_CODE_LAST) begin
                fail = 1'b1;
                code = ERR_START;
              end
            end else if (idx_w == CMP_W'(3)) begin
              sc_n = b;
            end else if (idx_w == CMP_W'(4)) begin
              len_hi = b;
              len_n  = {len_hi, 8'h00};
            end else begin
              len_n = len | {8'h00, b};
              if (sc inside {[AV_ID_LOW:AV_ID_HIGH]}) begin
                go_opt = 1'b1;
              end else begin
                hdone = 1'b1;
              end
            end
          end
          PH_OPT: begin
            if (idx_w == CMP_W'(7)) begin
              flg_n = b[7:6];
              if (flg_n == FLAGS_BAD) begin
                fail = 1'b1;
                code = ERR_FLAGS;
              end
            end else if (idx_w >= CMP_W'(8)) begin
              if (flg == FLAGS_PTS) begin
                need = NEED_PTS_ONLY;
              end else if (flg == FLAGS_PTS_DTS) begin
                need = NEED_PTS_DTS;
              end
              hdr_n = b;
              if (b < need) begin
                fail = 1'b1;
                code = ERR_SHORT;
              end else if (b == 8'h00) begin
                hdone = 1'b1;
              end else begin
                go_data = 1'b1;
              end
            end
          end
          PH_DATA: begin
            stamp_n = {stamp[31:0], b};
            ts      = {stamp_n[35:33], stamp_n[31:17], stamp_n[15:1]};
            if (flg[1]) begin
              // pts field ends at the fifth header data byte, dts at the tenth
              if (idx_w == CMP_W'(13)) begin
                ts_err = stamp_check(stamp_n,
                                     (flg == FLAGS_PTS_DTS) ? PREFIX_PTS_DTS : PREFIX_PTS_ONLY);
                if (ts_err != ERR_NONE) begin
                  fail = 1'b1;
                  code = ts_err;
                end else begin
                  pts_n = ts;
                  if (flg == FLAGS_PTS) begin
                    dts_n = ts;
                  end
                end
              end else if (idx_w == CMP_W'(18) && flg == FLAGS_PTS_DTS) begin
                ts_err = stamp_check(stamp_n, PREFIX_DTS);
                if (ts_err != ERR_NONE) begin
                  fail = 1'b1;
                  code = ts_err;
                end else begin
                  dts_n = ts;
                end
              end
            end
            if (!fail && idx_w >= CMP_W'(hdr) + CMP_W'(8)) begin
              hdone = 1'b1;
            end
          end
          PH_PAY: begin
            pay  = 1'b1;
            last = (len != 16'h0000) && (cnt_inc_w == CMP_W'(len) + CMP_W'(6));
          end
          default: begin
          end
        endcase
      end
    end

    end_w      = CMP_W'(len_n) + CMP_W'(6);
    hd_to_done = (len_n != 16'h0000) && (cnt_inc_w >= end_w);
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    sc_nxt    = sc_r;
    len_nxt   = len_r;
    flg_nxt   = flg_r;
    hdr_nxt   = hdr_r;
    stamp_nxt = stamp_r;
    pts_nxt   = pts_r;
    dts_nxt   = dts_r;
    if (acc) begin
      sc_nxt    = sc_n;
      len_nxt   = len_n;
      flg_nxt   = flg_n;
      hdr_nxt   = hdr_n;
      stamp_nxt = stamp_n;
      pts_nxt   = pts_n;
      dts_nxt   = dts_n;
      cnt_nxt   = (active && !oversize) ? cnt_inc : cnt;
      if (!active) begin
        phase_nxt = ph;
      end else if (fail) begin
        phase_nxt = PH_IDLE;
      end else if (hdone) begin
        phase_nxt = hd_to_done ? PH_DONE : PH_PAY;
      end else if (go_opt) begin
        phase_nxt = PH_OPT;
      end else if (go_data) begin
        phase_nxt = PH_DATA;
      end else if (pay && last) begin
        phase_nxt = PH_DONE;
      end else begin
        phase_nxt = ph;
      end
    end
  end

  // result
  always_comb begin
    res_valid_nxt = acc && active && (fail || hdone || pay);
    res_nxt = '0;
    res_nxt.stream_id  = sc_n;
    res_nxt.pes_length = len_n;
    if (fail) begin
      res_nxt.kind       = KIND_ERROR;
      res_nxt.error_code = code;
    end else if (hdone) begin
      res_nxt.kind           = KIND_HEADER;
      res_nxt.has_timestamps = flg_n[1];
      res_nxt.pts            = flg_n[1] ? pts_n : '0;
      res_nxt.dts            = flg_n[1] ? dts_n : '0;
    end else begin
      res_nxt.kind         = KIND_PAYLOAD;
      res_nxt.payload_byte = b;
      res_nxt.last_payload = last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      cnt_r       <= '0;
      sc_r        <= '0;
      len_r       <= '0;
      flg_r       <= '0;
      hdr_r       <= '0;
      stamp_r     <= '0;
      pts_r       <= '0;
      dts_r       <= '0;
      res_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      sc_r        <= sc_nxt;
      len_r       <= len_nxt;
      flg_r       <= flg_nxt;
      hdr_r       <= hdr_nxt;
      stamp_r     <= stamp_nxt;
      pts_r       <= pts_nxt;
      dts_r       <= dts_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule
`default_nettype wire

// File: hw/rtl/pesd_out_fifo.sv
`default_nettype none
module pesd_out_fifo
  import pesd_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire out_item_t      push_data,
  input  wire logic           pop,
  output out_item_t           head,
  output logic                not_empty,
  output logic [OUT_CNT_W-1:0] count
);

  out_item_t               mem_r [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [OUT_PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [OUT_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                    do_pop;

  assign do_pop = pop && (cnt_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ptr_r + OUT_PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : rd_ptr_r + OUT_PTR_W'(1);
    end
    cnt_nxt = cnt_r + OUT_CNT_W'(push) - OUT_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign head      = mem_r[rd_ptr_r];
  assign not_empty = cnt_r != '0;
  assign count     = cnt_r;

endmodule
`default_nettype wire

// File: hw/rtl/pes_packet_depacketizer.sv
// PES packet parser: takes one stream byte per cycle and gives at most one
// word per byte (a header report, an error report or a payload byte). Each
// byte is parsed in the cycle it is accepted and its result is registered,
// then queued in a three-entry output queue. Input is ready whenever the
// queue plus the result register hold fewer than three words, so with the
// output side taking words every cycle the block sustains one byte per
// cycle. A byte with packet_start set begins a new packet and clears all
// parse state; no clearing pass is needed.
`default_nettype none
module pes_packet_depacketizer
  import pesd_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  pesd_in_if.sink     in_ch,
  pesd_out_if.source  out_ch
);

  logic                  acc;
  in_item_t              item;
  logic                  res_valid;
  out_item_t             res;
  out_item_t             head;
  logic                  not_empty;
  logic [OUT_CNT_W-1:0]  q_count;
  logic [OUT_CNT_W:0]    in_flight;

  // words still owed: queued plus the one in the result register
  assign in_flight    = {1'b0, q_count} + {{OUT_CNT_W{1'b0}}, res_valid};
  assign in_ch.ready  = in_flight < (OUT_CNT_W + 1)'(OUT_DEPTH);
  assign acc          = in_ch.valid && in_ch.ready;
  assign item         = '{in_byte: in_ch.in_byte, packet_start: in_ch.packet_start};

  pesd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  pesd_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .pop       (out_ch.ready),
    .head      (head),
    .not_empty (not_empty),
    .count     (q_count)
  );

  assign out_ch.valid          = not_empty;
  assign out_ch.kind           = head.kind;
  assign out_ch.payload_byte   = head.payload_byte;
  assign out_ch.last_payload   = head.last_payload;
  assign out_ch.stream_id      = head.stream_id;
  assign out_ch.pes_length     = head.pes_length;
  assign out_ch.has_timestamps = head.has_timestamps;
  assign out_ch.pts            = head.pts;
  assign out_ch.dts            = head.dts;
  assign out_ch.error_code     = head.error_code;

endmodule
`default_nettype wire

// File: test/pesd_checker.sv
`timescale 1ns / 100ps
module pesd_checker
  import pesd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  pesd_in_if          in_mon,
  pesd_out_if         out_mon,
  output int unsigned fail_cnt,
  output int unsigned pending,
  output int unsigned hdr_seen,
  output int unsigned ts_seen,
  output int unsigned pay_seen,
  output int unsigned err_seen
);

  localparam int MAX_REPORTS = 40;

  // parser state mirrored from the stream
  phase_t      st_phase;
  int unsigned pkt_bytes;
  logic [7:0]  cur_sid;
  logic [15:0] cur_len;
  flags_t      cur_flags;
  logic [7:0]  hdr_data_len;
  logic [39:0] ts_shift;
  logic [32:0] pts_held;
  logic [32:0] dts_held;

  out_item_t   expected_words[$];

  function automatic void clear_parser();
    pkt_bytes    = 0;
    cur_sid      = '0;
    cur_len      = '0;
    cur_flags    = FLAGS_NONE;
    hdr_data_len = '0;
    ts_shift     = '0;
    pts_held     = '0;
    dts_held     = '0;
  endfunction

  function automatic out_item_t error_word(input err_t code);
    out_item_t w;
    w            = '0;
    st_phase     = PH_IDLE;
    w.kind       = KIND_ERROR;
    w.stream_id  = cur_sid;
    w.pes_length = cur_len;
    w.error_code = code;
    return w;
  endfunction

  function automatic out_item_t header_word();
    out_item_t w;
    w = '0;
    if (cur_len != 0 && pkt_bytes >= 6 + cur_len) st_phase = PH_DONE;
    else st_phase = PH_PAY;
    w.kind       = KIND_HEADER;
    w.stream_id  = cur_sid;
    w.pes_length = cur_len;
    if (cur_flags[1]) begin
      w.has_timestamps = 1'b1;
      w.pts            = pts_held;
      w.dts            = dts_held;
    end
    return w;
  endfunction

  // 40-bit field: prefix, 3 bits, marker, 15 bits, marker, 15 bits, marker
  function automatic err_t unpack_stamp(input logic [39:0] v, input logic [3:0] prefix,
                                        output logic [32:0] ts);
    ts = {v[35:33], v[31:17], v[15:1]};
    if (v[39:36] != prefix) return ERR_PREFIX;
    if (!v[32] || !v[16] || !v[0]) return ERR_MARKER;
    return ERR_NONE;
  endfunction

  function automatic bit parse_byte(input logic [7:0] b, input logic start,
                                    output out_item_t w);
    int unsigned idx;
    int unsigned k;
    err_t        e;
    logic [32:0] ts;
    logic [7:0]  need;
    w = '0;
    if (start) begin
      clear_parser();
      st_phase = PH_HEAD;
    end
    if (st_phase != PH_HEAD && st_phase != PH_OPT && st_phase != PH_DATA &&
        st_phase != PH_PAY) return 1'b0;
    if (pkt_bytes >= MAX_PACKET_BYTES) begin
      w = error_word(ERR_OVERSIZE);
      return 1'b1;
    end
    idx = pkt_bytes;
    pkt_bytes++;
    case (st_phase)
      PH_HEAD: begin
        if (idx < 2) begin
          if (b != 8'h00) begin
            w = error_word(ERR_START);
            return 1'b1;
          end
        end else if (idx == 2) begin
          if (b != START_CODE_LAST) begin
            w = error_word(ERR_START);
            return 1'b1;
          end
        end else if (idx == 3) begin
          cur_sid = b;
        end else if (idx == 4) begin
          cur_len = {b, 8'h00};
        end else begin
          cur_len[7:0] = b;
          if (cur_sid >= AV_ID_LOW && cur_sid <= AV_ID_HIGH) begin
            st_phase = PH_OPT;
          end else begin
            w = header_word();
            return 1'b1;
          end
        end
        return 1'b0;
      end
      PH_OPT: begin
        if (idx == 7) begin
          cur_flags = flags_t'(b[7:6]);
          if (cur_flags == FLAGS_BAD) begin
            w = error_word(ERR_FLAGS);
            return 1'b1;
          end
        end else if (idx >= 8) begin
          need = (cur_flags == FLAGS_PTS) ? NEED_PTS_ONLY :
                 (cur_flags == FLAGS_PTS_DTS) ? NEED_PTS_DTS : 8'd0;
          hdr_data_len = b;
          if (b < need) begin
            w = error_word(ERR_SHORT);
            return 1'b1;
          end
          if (b == 8'd0) begin
            w = header_word();
            return 1'b1;
          end
          st_phase = PH_DATA;
        end
        return 1'b0;
      end
      PH_DATA: begin
        k = idx - 9;
        ts_shift = {ts_shift[31:0], b};
        if (cur_flags[1]) begin
          if (k == 4) begin
            e = unpack_stamp(ts_shift, (cur_flags == FLAGS_PTS_DTS) ? PREFIX_PTS_DTS :
                             PREFIX_PTS_ONLY, ts);
            if (e != ERR_NONE) begin
              w = error_word(e);
              return 1'b1;
            end
            pts_held = ts;
            if (cur_flags == FLAGS_PTS) dts_held = ts;
          end else if (k == 9 && cur_flags == FLAGS_PTS_DTS) begin
            e = unpack_stamp(ts_shift, PREFIX_DTS, ts);
            if (e != ERR_NONE) begin
              w = error_word(e);
              return 1'b1;
            end
            dts_held = ts;
          end
        end
        if (k + 1 >= hdr_data_len) begin
          w = header_word();
          return 1'b1;
        end
        return 1'b0;
      end
      default: begin
        w.kind         = KIND_PAYLOAD;
        w.payload_byte = b;
        w.stream_id    = cur_sid;
        w.pes_length   = cur_len;
        if (cur_len != 0 && pkt_bytes == 6 + cur_len) begin
          w.last_payload = 1'b1;
          st_phase       = PH_DONE;
        end
        return 1'b1;
      end
    endcase
  endfunction

  task automatic check_field(input string name, input logic [32:0] want_v,
                             input logic [32:0] got_v);
    if (want_v !== got_v) begin
      if (fail_cnt < MAX_REPORTS)
        $error("%s: expected %0h, got %0h", name, want_v, got_v);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin : monitor
    out_item_t want;
    out_item_t got;
    out_item_t res;
    if (!rst_n) begin
      st_phase = PH_IDLE;
      clear_parser();
      expected_words.delete();
      fail_cnt = 0;
      hdr_seen = 0;
      ts_seen  = 0;
      pay_seen = 0;
      err_seen = 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        if (parse_byte(in_mon.in_byte, in_mon.packet_start, res))
          expected_words.push_back(res);
      end
      if (out_mon.valid && out_mon.ready) begin
        got.kind           = out_mon.kind;
        got.payload_byte   = out_mon.payload_byte;
        got.last_payload   = out_mon.last_payload;
        got.stream_id      = out_mon.stream_id;
        got.pes_length     = out_mon.pes_length;
        got.has_timestamps = out_mon.has_timestamps;
        got.pts            = out_mon.pts;
        got.dts            = out_mon.dts;
        got.error_code     = out_mon.error_code;
        if (expected_words.size() == 0) begin
          if (fail_cnt < MAX_REPORTS)
            $error("word of kind %0d arrived with nothing expected", got.kind);
          fail_cnt++;
        end else begin
          want = expected_words.pop_front();
          check_field("kind", want.kind, got.kind);
          check_field("payload_byte", want.payload_byte, got.payload_byte);
          check_field("last_payload", want.last_payload, got.last_payload);
          check_field("stream_id", want.stream_id, got.stream_id);
          check_field("pes_length", want.pes_length, got.pes_length);
          check_field("has_timestamps", want.has_timestamps, got.has_timestamps);
          check_field("pts", want.pts, got.pts);
          check_field("dts", want.dts, got.dts);
          check_field("error_code", want.error_code, got.error_code);
          if (want.kind == KIND_HEADER) begin
            hdr_seen++;
            if (want.has_timestamps) ts_seen++;
          end else if (want.kind == KIND_PAYLOAD) begin
            pay_seen++;
          end else begin
            err_seen++;
          end
        end
      end
    end
    pending <= expected_words.size();
  end

endmodule

// File: test/tb_pes_packet_depacketizer.sv
`timescale 1ns / 100ps
module tb_pes_packet_depacketizer;
  import pesd_pkg::*;

  localparam int QUIET_LIMIT   = 2000;
  localparam int PHASE_BYTES   = 260;
  localparam int DRAIN_CYCLES  = 8;

  logic        clk;
  logic        rst_n;
  int unsigned in_idle_pct;
  int unsigned out_stall_pct;
  int unsigned bytes_sent;
  int unsigned quiet_cycles;
  int unsigned fail_cnt;
  int unsigned pending;
  int unsigned hdr_seen;
  int unsigned ts_seen;
  int unsigned pay_seen;
  int unsigned err_seen;
  logic [7:0]  pkt[$];

  pesd_in_if  in_bus ();
  pesd_out_if out_bus ();

  pes_packet_depacketizer i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  pesd_checker i_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_mon   (in_bus),
    .out_mon  (out_bus),
    .fail_cnt (fail_cnt),
    .pending  (pending),
    .hdr_seen (hdr_seen),
    .ts_seen  (ts_seen),
    .pay_seen (pay_seen),
    .err_seen (err_seen)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    out_bus.ready <= ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("** pes_packet_depacketizer: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [39:0] stamp_field(input logic [3:0] prefix, input logic [32:0] ts);
    return {prefix, ts[32:30], 1'b1, ts[29:15], 1'b1, ts[14:0], 1'b1};
  endfunction

  // builds a packet into pkt; a negative len_sel puts the true length in the length field
  function automatic void make_packet(input logic [7:0] sid, input flags_t fl,
                                      input logic [7:0] hl, input logic [32:0] p,
                                      input logic [32:0] d, input int pay_n,
                                      input int len_sel);
    logic [39:0] sw;
    logic [7:0]  hdr[$];
    int          lenv;
    pkt = {};
    pkt.push_back(8'h00);
    pkt.push_back(8'h00);
    pkt.push_back(START_CODE_LAST);
    pkt.push_back(sid);
    pkt.push_back(8'h00);
    pkt.push_back(8'h00);
    if (sid >= AV_ID_LOW && sid <= AV_ID_HIGH) begin
      pkt.push_back(8'($urandom));
      pkt.push_back({fl, 6'($urandom)});
      pkt.push_back(hl);
      if (fl[1]) begin
        sw = stamp_field((fl == FLAGS_PTS_DTS) ? PREFIX_PTS_DTS : PREFIX_PTS_ONLY, p);
        for (int i = 0; i < 5; i++) hdr.push_back(sw[39 - 8 * i -: 8]);
      end
      if (fl == FLAGS_PTS_DTS) begin
        sw = stamp_field(PREFIX_DTS, d);
        for (int i = 0; i < 5; i++) hdr.push_back(sw[39 - 8 * i -: 8]);
      end
      for (int i = 0; i < hl; i++) pkt.push_back((i < hdr.size()) ? hdr[i] : 8'($urandom));
    end
    lenv = (len_sel < 0) ? (pkt.size() - 6 + pay_n) : len_sel;
    repeat (pay_n) pkt.push_back(8'($urandom));
    pkt[4] = lenv[15:8];
    pkt[5] = lenv[7:0];
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic start);
    while ($urandom_range(99) < in_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.in_byte      <= b;
    in_bus.packet_start <= start;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_packet();
    foreach (pkt[i]) push_byte(pkt[i], i == 0);
  endtask

  task automatic directed_cases();
    logic [32:0] p;
    int          pos[6];
    logic [7:0]  mask[6];
    pos  = '{9, 9, 11, 13, 14, 18};
    mask = '{8'h10, 8'h01, 8'h01, 8'h01, 8'h10, 8'h01};
    p    = {1'($urandom), 32'($urandom)};
    // stray bytes before any packet start
    push_byte(8'hA5, 1'b0);
    push_byte(8'h00, 1'b0);
    // plain stream with exact length, then a byte past its end
    make_packet(8'hBE, FLAGS_NONE, 0, 0, 0, 3, -1);
    pkt[6] = 8'h00;
    pkt[8] = 8'hFF;
    send_packet();
    push_byte(8'h5A, 1'b0);
    // unbounded length, then max length cut short by the next start
    make_packet(8'h00, FLAGS_NONE, 0, 0, 0, 2, 0);
    send_packet();
    make_packet(8'hFF, FLAGS_NONE, 0, 0, 0, 2, 16'hFFFF);
    send_packet();
    // ids just outside the audio/video range
    make_packet(8'hBF, FLAGS_NONE, 0, 0, 0, 1, -1);
    send_packet();
    make_packet(8'hF0, FLAGS_NONE, 0, 0, 0, 1, -1);
    send_packet();
    // timestamps at their extremes, with and without stuffing
    make_packet(8'hE0, FLAGS_PTS, 5, 33'h1FFFFFFFF, 0, 2, -1);
    send_packet();
    make_packet(8'hC0, FLAGS_PTS_DTS, 12, 33'h0, 33'h1FFFFFFFF, 2, -1);
    send_packet();
    // no timestamps: empty and skipped header data
    make_packet(8'hEF, FLAGS_NONE, 0, 0, 0, 2, -1);
    send_packet();
    make_packet(8'hDF, FLAGS_NONE, 3, 0, 0, 1, -1);
    send_packet();
    // forbidden flags and too-short header data
    make_packet(8'hE5, FLAGS_BAD, 0, 0, 0, 1, -1);
    send_packet();
    make_packet(8'hE6, FLAGS_PTS, 4, p, p, 1, -1);
    send_packet();
    make_packet(8'hC7, FLAGS_PTS_DTS, 9, p, p, 1, -1);
    send_packet();
    // bad start code at each position
    for (int i = 0; i < 3; i++) begin
      make_packet(8'hE1, FLAGS_PTS, 5, p, p, 1, -1);
      pkt[i] = (i == 2) ? 8'h00 : 8'hFF;
      send_packet();
    end
    // prefix and marker faults in pts and dts
    for (int i = 0; i < 6; i++) begin
      make_packet(8'hE2, FLAGS_PTS_DTS, 10, p, ~p, 1, -1);
      pkt[pos[i]] = pkt[pos[i]] ^ mask[i];
      send_packet();
    end
    // length ends inside the header, and exactly at its end
    make_packet(8'hE3, FLAGS_PTS, 5, p, p, 3, 2);
    send_packet();
    make_packet(8'hC3, FLAGS_PTS, 5, p, p, 0, -1);
    send_packet();
    // packets abandoned in the payload and in the header
    make_packet(8'hE4, FLAGS_NONE, 0, 0, 0, 6, -1);
    pkt = pkt[0:9];
    send_packet();
    make_packet(8'hE4, FLAGS_NONE, 0, 0, 0, 6, -1);
    pkt = pkt[0:3];
    send_packet();
  endtask

  task automatic rand_packet();
    int unsigned r;
    int unsigned sel;
    int unsigned n;
    int unsigned hi;
    logic [7:0]  sid;
    logic [7:0]  hl;
    flags_t      fl;
    logic [32:0] p;
    logic [32:0] d;
    int          len_sel;
    r = $urandom_range(99);
    if (r >= 92) begin
      // loose bytes, now and then with a start flag
      repeat ($urandom_range(8, 1)) push_byte(8'($urandom), $urandom_range(9) == 0);
      return;
    end
    sel = $urandom_range(3);
    if (sel < 2) sid = {4'hE, 4'($urandom)};
    else if (sel == 2) sid = AV_ID_LOW + 8'($urandom_range(31));
    else sid = 8'($urandom);
    sel = $urandom_range(99);
    if (sel < 40) fl = FLAGS_PTS;
    else if (sel < 75) fl = FLAGS_PTS_DTS;
    else if (sel < 95) fl = FLAGS_NONE;
    else fl = FLAGS_BAD;
    if ($urandom_range(9) == 0) begin
      hl = 8'($urandom_range(40));
    end else begin
      hl = (fl == FLAGS_PTS) ? NEED_PTS_ONLY : (fl == FLAGS_PTS_DTS) ? NEED_PTS_DTS : 8'd0;
      hl = hl + 8'($urandom_range(4));
    end
    p = {1'($urandom), 32'($urandom)};
    d = {1'($urandom), 32'($urandom)};
    n = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(15);
    sel = $urandom_range(99);
    if (sel < 60) len_sel = -1;
    else if (sel < 80) len_sel = 0;
    else if (sel < 95) len_sel = $urandom_range(n + 20);
    else len_sel = $urandom_range(16'hFFFF);
    make_packet(sid, fl, hl, p, d, n, len_sel);
    if (r >= 65 && r < 85) begin
      hi = (pkt.size() > 20) ? 20 : pkt.size() - 1;
      sel = $urandom_range(hi);
      pkt[sel] = pkt[sel] ^ (8'h01 << $urandom_range(7));
    end else if (r >= 85) begin
      pkt = pkt[0:$urandom_range(pkt.size() - 1)];
    end
    send_packet();
    if ($urandom_range(9) == 0)
      repeat ($urandom_range(3, 1)) push_byte(8'($urandom), 1'b0);
  endtask

  initial begin
    int unsigned target;
    clk                 = 1'b0;
    rst_n               = 1'b0;
    in_idle_pct         = 0;
    out_stall_pct       = 0;
    bytes_sent          = 0;
    quiet_cycles        = 0;
    in_bus.valid        = 1'b0;
    in_bus.in_byte      = 8'h00;
    in_bus.packet_start = 1'b0;
    out_bus.ready       = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_cases();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 71; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 71; end
        default: begin in_idle_pct = 33; out_stall_pct = 33; end
      endcase
      target = bytes_sent + PHASE_BYTES;
      while (bytes_sent < target) rand_packet();
    end
    in_bus.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    $display("sent %0d bytes: directed corner packets, then four traffic phases",
             bytes_sent);
    $display("checked %0d headers (%0d with timestamps), %0d payload bytes, %0d errors",
             hdr_seen, ts_seen, pay_seen, err_seen);
    if (fail_cnt == 0) begin
      $display("** pes_packet_depacketizer: PASSED **");
    end else begin
      $display("** pes_packet_depacketizer: FAILED **");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/pesd_pkg.sv
hw/rtl/pesd_in_if.sv
hw/rtl/pesd_out_if.sv
hw/rtl/pesd_parser.sv
hw/rtl/pesd_out_fifo.sv
hw/rtl/pes_packet_depacketizer.sv
test/pesd_checker.sv
test/tb_pes_packet_depacketizer.sv
